// File: hdl/tsbdssa_pkg.sv
// ----------------------------------------------------------------------------
// tsbdssa_pkg
// Types and constants shared by the two-strain birth-death event stepper and
// its port checker.
// ----------------------------------------------------------------------------
package tsbdssa_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] uniform_draw;
        logic [31:0] exp_draw;
    } in_t;

    typedef struct packed {
        logic [15:0] sensitive_count;
        logic [15:0] resistant_count;
        logic [47:0] elapsed_time;
        logic [2:0]  event_kind;
        logic [1:0]  run_status;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_UPD,
        ST_PHASE,
        ST_FINISH
    } state_t;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_KILL_S      = 3'd1;
    localparam logic [2:0] CFG_KILL_R      = 3'd2;
    localparam logic [2:0] CFG_TREAT_END   = 3'd3;
    localparam logic [2:0] CFG_BIRTH_S     = 3'd4;
    localparam logic [2:0] CFG_BIRTH_R     = 3'd5;
    localparam logic [2:0] CFG_CROWD       = 3'd6;
    localparam logic [2:0] CFG_INIT_S      = 3'd7;

    // Event codes.
    localparam logic [2:0] EV_S_BIRTH = 3'd0;
    localparam logic [2:0] EV_S_DEATH = 3'd1;
    localparam logic [2:0] EV_R_BIRTH = 3'd2;
    localparam logic [2:0] EV_R_DEATH = 3'd3;
    localparam logic [2:0] EV_NONE    = 3'd4;

    // Run status codes.
    localparam logic [1:0] RUN_ACTIVE  = 2'd0;
    localparam logic [1:0] RUN_SUCCESS = 2'd1;
    localparam logic [1:0] RUN_FAILED  = 2'd2;

    localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] POP_MAX    = 16'hFFFF;
    localparam logic [33:0] DEATH_Q16  = 34'd32768;

    localparam logic [23:0] BIRTH_S_RST = 24'd720896;
    localparam logic [23:0] BIRTH_R_RST = 24'd694682;
    localparam logic [31:0] CROWD_RST   = 32'd4294967;
    localparam logic [15:0] INIT_S_RST  = 16'd10500;

    // Last step of the multiply, compare and divide phases of the sequencer.
    localparam logic [5:0] MUL_LAST = 6'd11;
    localparam logic [5:0] CMP_LAST = 6'd3;
    localparam logic [5:0] DIV_LAST = 6'd55;

endpackage

// File: hdl/two_strain_birth_death_ssa_step.sv
// ----------------------------------------------------------------------------
// two_strain_birth_death_ssa_step
// One Gillespie direct-method event per item for a two-strain birth-death
// population model, built around one shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
// An event item passes from acceptance to the result being offered through
// the shared 34 by 17 bit multiplier (crowding term, four event rates and
// the 32 by 52 bit selection product in four partial products), cumulative
// comparison, then, unless the total rate is zero, the one-bit-per-cycle
// divider that forms the waiting time, update and phase check, and last the
// output load. A start item, or an event item arriving with no run active,
// goes straight to the output load. The input is stalled for the whole time
// an item is in work; the finished result sits in an output register and
// the block returns to accept the next item as soon as that register has
// been loaded. Configuration registers are written through a plain write
// port and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module two_strain_birth_death_ssa_step
    import tsbdssa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data
);

    // Configuration registers.
    logic        mode_reg;
    logic [25:0] kill_s_reg;
    logic [25:0] kill_r_reg;
    logic [31:0] tend_reg;
    logic [23:0] birth_s_reg;
    logic [23:0] birth_r_reg;
    logic [31:0] crowd_coef_reg;
    logic [15:0] init_s_reg;

    // Run state.
    logic [15:0] sens_reg;
    logic [15:0] res_reg;
    logic [47:0] time_reg;
    logic        post_reg;
    logic [1:0]  status_reg;

    // Sequencer.
    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  cnt_reg;

    // Datapath working registers.
    logic [31:0] u_reg;
    logic [23:0] bs_eff_reg;
    logic [23:0] br_eff_reg;
    logic [33:0] ds_reg;
    logic [33:0] dr_reg;
    logic [50:0] prod_reg;
    logic [49:0] rate_reg [4];
    logic [51:0] total_reg;
    logic [83:0] acc_reg;
    logic [51:0] cum_reg;
    logic        found_reg;
    logic [2:0]  kind_reg;
    logic [51:0] rem_reg;
    logic [55:0] dvd_reg;
    out_t        out_reg;
    logic        out_valid_reg;

    logic        in_accept;
    logic        out_free;
    logic        drug;
    logic [33:0] mul_a;
    logic [16:0] mul_b;
    logic [32:0] crowd;
    logic [51:0] sel;
    logic [51:0] cum_next;
    logic [52:0] trial;
    logic        trial_ge;
    logic [56:0] time_sum;
    logic [47:0] tend_q;
    logic        late;

    assign in_accept = in_valid && !in_stall;
    // The output register can take a new result when empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    // While treatment lasts the drug takes part in the rates.
    assign drug      = !post_reg;
    assign crowd     = prod_reg[48:16];
    assign sel       = acc_reg[83:32];
    assign cum_next  = cum_reg + {2'b00, rate_reg[cnt_reg[1:0]]};
    assign trial     = {rem_reg, dvd_reg[55]};
    assign trial_ge  = trial >= {1'b0, total_reg};
    assign time_sum  = {9'd0, time_reg} + {1'b0, dvd_reg};
    assign tend_q    = {tend_reg, 16'd0};
    assign late      = time_reg > tend_q;

    // Operand selection for the shared multiplier. The product is registered
    // and taken up in the cycle after the operands were issued.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cnt_reg)
            6'd0:
            begin
                mul_a = {2'b00, crowd_coef_reg};
                mul_b = {1'b0, sens_reg} + {1'b0, res_reg};
            end
            6'd2:
            begin
                mul_a = {10'd0, bs_eff_reg};
                mul_b = {1'b0, sens_reg};
            end
            6'd3:
            begin
                mul_a = {10'd0, br_eff_reg};
                mul_b = {1'b0, res_reg};
            end
            6'd4:
            begin
                mul_a = ds_reg;
                mul_b = {1'b0, sens_reg};
            end
            6'd5:
            begin
                mul_a = dr_reg;
                mul_b = {1'b0, res_reg};
            end
            6'd7:
            begin
                mul_a = {2'b00, u_reg};
                mul_b = total_reg[16:0];
            end
            6'd8:
            begin
                mul_a = {2'b00, u_reg};
                mul_b = total_reg[33:17];
            end
            6'd9:
            begin
                mul_a = {2'b00, u_reg};
                mul_b = total_reg[50:34];
            end
            6'd10:
            begin
                mul_a = {2'b00, u_reg};
                mul_b = {16'd0, total_reg[51]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.action && status_reg == RUN_ACTIVE)
                        state_next = ST_MUL;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cnt_reg == CMP_LAST)
                    state_next = (total_reg == '0) ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_UPD;
            end
            ST_UPD:
                state_next = ST_PHASE;
            ST_PHASE:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= 1'b0;
            kill_s_reg     <= '0;
            kill_r_reg     <= '0;
            tend_reg       <= '0;
            birth_s_reg    <= BIRTH_S_RST;
            birth_r_reg    <= BIRTH_R_RST;
            crowd_coef_reg <= CROWD_RST;
            init_s_reg     <= INIT_S_RST;
            sens_reg       <= '0;
            res_reg        <= '0;
            time_reg       <= '0;
            post_reg       <= 1'b0;
            status_reg     <= RUN_FAILED;
        end
        else
        begin
            state_reg <= state_next;

            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 6'd1;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:      mode_reg       <= cfg_data[0];
                    CFG_KILL_S:    kill_s_reg     <= cfg_data[25:0];
                    CFG_KILL_R:    kill_r_reg     <= cfg_data[25:0];
                    CFG_TREAT_END: tend_reg       <= cfg_data;
                    CFG_BIRTH_S:   birth_s_reg    <= cfg_data[23:0];
                    CFG_BIRTH_R:   birth_r_reg    <= cfg_data[23:0];
                    CFG_CROWD:     crowd_coef_reg <= cfg_data;
                    CFG_INIT_S:    init_s_reg     <= cfg_data[15:0];
                    default:       mode_reg       <= mode_reg;
                endcase
            end

            // A start item resets the run.
            if (state_reg == ST_IDLE && in_accept && !in_data.action)
            begin
                sens_reg   <= init_s_reg;
                res_reg    <= 16'd1;
                time_reg   <= '0;
                post_reg   <= 1'b0;
                status_reg <= RUN_ACTIVE;
            end

            // Time advances with saturation and the chosen event is applied.
            if (state_reg == ST_UPD)
            begin
                time_reg <= (time_sum > {9'd0, TIME_MAX}) ? TIME_MAX : time_sum[47:0];
                case (kind_reg)
                    EV_S_BIRTH:
                    begin
                        if (sens_reg != POP_MAX)
                            sens_reg <= sens_reg + 16'd1;
                    end
                    EV_S_DEATH:
                    begin
                        if (sens_reg != '0)
                            sens_reg <= sens_reg - 16'd1;
                    end
                    EV_R_BIRTH:
                    begin
                        if (res_reg != POP_MAX)
                            res_reg <= res_reg + 16'd1;
                    end
                    default:
                    begin
                        if (res_reg != '0)
                            res_reg <= res_reg - 16'd1;
                    end
                endcase
            end

            // End of the treatment phase and end of the run.
            if (state_reg == ST_PHASE)
            begin
                if (!post_reg)
                begin
                    if (late || res_reg == '0)
                    begin
                        if (sens_reg == '0)
                            sens_reg <= 16'd1;
                        if (res_reg == '0)
                            status_reg <= late ? RUN_SUCCESS : RUN_FAILED;
                        else
                            post_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (res_reg == '0)
                        status_reg <= RUN_SUCCESS;
                    else if (sens_reg == '0)
                        status_reg <= RUN_FAILED;
                end
            end

            if (state_reg == ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath working registers, which need no reset.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        case (state_reg)
            ST_IDLE:
            begin
                u_reg     <= in_data.uniform_draw;
                dvd_reg   <= {in_data.exp_draw, 24'd0};
                total_reg <= '0;
                acc_reg   <= '0;
                kind_reg  <= EV_NONE;
            end
            ST_MUL:
            begin
                case (cnt_reg)
                    6'd1:
                    begin
                        // Effective per-cell rates once the crowding term is known.
                        if (drug && !mode_reg)
                        begin
                            bs_eff_reg <= ({2'b00, birth_s_reg} > kill_s_reg) ?
                                          birth_s_reg - kill_s_reg[23:0] : '0;
                            br_eff_reg <= ({2'b00, birth_r_reg} > kill_r_reg) ?
                                          birth_r_reg - kill_r_reg[23:0] : '0;
                        end
                        else
                        begin
                            bs_eff_reg <= birth_s_reg;
                            br_eff_reg <= birth_r_reg;
                        end
                        if (drug && mode_reg)
                        begin
                            ds_reg <= DEATH_Q16 + {1'b0, crowd} + {8'd0, kill_s_reg};
                            dr_reg <= DEATH_Q16 + {1'b0, crowd} + {8'd0, kill_r_reg};
                        end
                        else
                        begin
                            ds_reg <= DEATH_Q16 + {1'b0, crowd};
                            dr_reg <= DEATH_Q16 + {1'b0, crowd};
                        end
                    end
                    6'd3:
                    begin
                        rate_reg[0] <= prod_reg[49:0];
                        total_reg   <= total_reg + {2'b00, prod_reg[49:0]};
                    end
                    6'd4:
                    begin
                        rate_reg[2] <= prod_reg[49:0];
                        total_reg   <= total_reg + {2'b00, prod_reg[49:0]};
                    end
                    6'd5:
                    begin
                        rate_reg[1] <= prod_reg[49:0];
                        total_reg   <= total_reg + {2'b00, prod_reg[49:0]};
                    end
                    6'd6:
                    begin
                        rate_reg[3] <= prod_reg[49:0];
                        total_reg   <= total_reg + {2'b00, prod_reg[49:0]};
                    end
                    6'd8:  acc_reg <= acc_reg + {33'd0, prod_reg};
                    6'd9:  acc_reg <= acc_reg + {16'd0, prod_reg, 17'd0};
                    6'd10: acc_reg <= acc_reg + {prod_reg[49:0], 34'd0};
                    6'd11: acc_reg <= acc_reg + {prod_reg[32:0], 51'd0};
                    default: acc_reg <= acc_reg;
                endcase
                cum_reg   <= '0;
                found_reg <= 1'b0;
                kind_reg  <= EV_S_BIRTH;
            end
            ST_CMP:
            begin
                // First event whose cumulative rate exceeds the selection value.
                cum_reg <= cum_next;
                if (cnt_reg == CMP_LAST && total_reg == '0)
                    kind_reg <= EV_NONE;
                else if (!found_reg && sel < cum_next)
                begin
                    found_reg <= 1'b1;
                    kind_reg  <= {1'b0, cnt_reg[1:0]};
                end
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                // Restoring division; the quotient shifts in behind the dividend.
                if (trial_ge)
                    rem_reg <= trial[51:0] - total_reg;
                else
                    rem_reg <= trial[51:0];
                dvd_reg <= {dvd_reg[54:0], trial_ge};
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_reg.sensitive_count <= sens_reg;
                    out_reg.resistant_count <= res_reg;
                    out_reg.elapsed_time    <= time_reg;
                    out_reg.event_kind      <= kind_reg;
                    out_reg.run_status      <= status_reg;
                end
            end
            default:
                u_reg <= u_reg;
        endcase
    end

endmodule

// File: hdl/tsbdssa_checker.sv
// ----------------------------------------------------------------------------
// tsbdssa_checker
// Port-level checks for the two-strain birth-death event stepper.
// ----------------------------------------------------------------------------
module tsbdssa_checker
    import tsbdssa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input out_t        out_data
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a second item straight away");

    // Only defined event codes appear.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.event_kind == EV_S_BIRTH ||
                       out_data.event_kind == EV_S_DEATH ||
                       out_data.event_kind == EV_R_BIRTH ||
                       out_data.event_kind == EV_R_DEATH ||
                       out_data.event_kind == EV_NONE))
        else $error("undefined event code");

    // A result with no event and a status other than running has a defined run status.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.run_status != RUN_ACTIVE && out_data.event_kind == EV_NONE
        |-> (out_data.run_status == RUN_SUCCESS || out_data.run_status == RUN_FAILED))
        else $error("undefined run status");

endmodule

bind two_strain_birth_death_ssa_step tsbdssa_checker u_tsbdssa_checker (.*);

// File: tb/two_strain_birth_death_ssa_step_tb.sv
// ----------------------------------------------------------------------------
// two_strain_birth_death_ssa_step_tb
// Self-checking bench for the two-strain birth-death event stepper. A driver
// feeds items from a queue. A predictor computes each item's result when the
// item is accepted, and a monitor compares every result with the oldest
// prediction. The run passes through several register settings and several
// idling patterns.
// ----------------------------------------------------------------------------
module two_strain_birth_death_ssa_step_tb;
    import tsbdssa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound on the whole run: stalls can stretch the work on each item,
    // but this is well above any correct run.
    localparam int CYCLE_LIMIT = 2000000;
    // Idle time allowed before a register write, well beyond what the block
    // needs for an event.
    localparam int SETTLE_CYCLES = 120;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;

    two_strain_birth_death_ssa_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // The testbench's own copy of the configuration registers.
    logic        mdl_mode;
    logic [25:0] mdl_kill_s;
    logic [25:0] mdl_kill_r;
    logic [31:0] mdl_treat_end;
    logic [23:0] mdl_birth_s;
    logic [23:0] mdl_birth_r;
    logic [31:0] mdl_crowd;
    logic [15:0] mdl_init_s;

    // The testbench's own copy of the population state.
    logic [15:0] pop_s;
    logic [15:0] pop_r;
    logic [47:0] sim_clock;
    logic        after_treatment;
    logic [1:0]  run_state;

    in_t  pending_items[$];
    out_t predicted_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Advances the population model by one item and returns the result that
    // the block is expected to produce.
    function automatic out_t predict_step(in_t it);
        out_t        res;
        logic [63:0] crowd_term;
        logic [63:0] b_s, d_s, b_r, d_r;
        logic [63:0] cum0, cum1, cum2, total;
        logic [63:0] sel, dt, tend;
        logic [2:0]  kind;
        logic        drug;

        kind = EV_NONE;
        if (it.action == 1'b0)
        begin
            // A new run: the draws play no part.
            pop_s = mdl_init_s;
            pop_r = 16'd1;
            sim_clock = '0;
            after_treatment = 1'b0;
            run_state = RUN_ACTIVE;
        end
        else if (run_state == RUN_ACTIVE)
        begin
            drug = !after_treatment;
            crowd_term = (64'(mdl_crowd) * (64'(pop_s) + 64'(pop_r))) >> 16;
            b_s = 64'(mdl_birth_s);
            b_r = 64'(mdl_birth_r);
            d_s = 64'(DEATH_Q16) + crowd_term;
            d_r = d_s;
            if (drug)
            begin
                if (mdl_mode == 1'b0)
                begin
                    // Bacteriostatic: the drug lowers birth, floored at zero.
                    b_s = (b_s > 64'(mdl_kill_s)) ? b_s - 64'(mdl_kill_s) : 64'd0;
                    b_r = (b_r > 64'(mdl_kill_r)) ? b_r - 64'(mdl_kill_r) : 64'd0;
                end
                else
                begin
                    // Bactericidal: the drug adds to death.
                    d_s = d_s + 64'(mdl_kill_s);
                    d_r = d_r + 64'(mdl_kill_r);
                end
            end
            cum0 = b_s * 64'(pop_s);
            cum1 = cum0 + d_s * 64'(pop_s);
            cum2 = cum1 + b_r * 64'(pop_r);
            total = cum2 + d_r * 64'(pop_r);
            if (total != 64'd0)
            begin
                sel = 64'(it.uniform_draw) * (total >> 32)
                    + ((64'(it.uniform_draw) * (total & 64'hFFFF_FFFF)) >> 32);
                if (sel < cum0)
                    kind = EV_S_BIRTH;
                else if (sel < cum1)
                    kind = EV_S_DEATH;
                else if (sel < cum2)
                    kind = EV_R_BIRTH;
                else
                    kind = EV_R_DEATH;

                dt = (64'(it.exp_draw) << 24) / total;
                if (dt > 64'(TIME_MAX) - 64'(sim_clock))
                    sim_clock = TIME_MAX;
                else
                    sim_clock = sim_clock + dt[47:0];

                case (kind)
                    EV_S_BIRTH: if (pop_s != POP_MAX) pop_s = pop_s + 16'd1;
                    EV_S_DEATH: if (pop_s != 16'd0) pop_s = pop_s - 16'd1;
                    EV_R_BIRTH: if (pop_r != POP_MAX) pop_r = pop_r + 16'd1;
                    default:    if (pop_r != 16'd0) pop_r = pop_r - 16'd1;
                endcase

                tend = 64'(mdl_treat_end) << 16;
                if (!after_treatment)
                begin
                    // Treatment ends on time or on extinction of the resistant strain.
                    if (64'(sim_clock) > tend || pop_r == 16'd0)
                    begin
                        if (pop_s == 16'd0)
                            pop_s = 16'd1;
                        if (pop_r == 16'd0)
                            run_state = (64'(sim_clock) > tend) ? RUN_SUCCESS : RUN_FAILED;
                        else
                            after_treatment = 1'b1;
                    end
                end
                else if (pop_r == 16'd0)
                    run_state = RUN_SUCCESS;
                else if (pop_s == 16'd0)
                    run_state = RUN_FAILED;
            end
        end
        res.sensitive_count = pop_s;
        res.resistant_count = pop_r;
        res.elapsed_time = sim_clock;
        res.event_kind = kind;
        res.run_status = run_state;
        return res;
    endfunction

    // Driver: offers the front of the pending queue and predicts each item as
    // it is accepted. The payload stays fixed while the item waits.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            logic accepted;
            accepted = in_valid && !in_stall;
            if (accepted)
            begin
                predicted_results.push_back(predict_step(in_data));
                void'(pending_items.pop_front());
            end
            if (in_valid && !accepted)
            begin
                // Hold the item that is waiting.
            end
            else if (pending_items.size() != 0
                     && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_items[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result against the oldest prediction and
    // drives a random stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(out_data), 64'd0);
                end
                else
                begin
                    out_t want;
                    want = predicted_results.pop_front();
                    if (out_data.sensitive_count !== want.sensitive_count)
                        report_mismatch("sensitive_count", 64'(out_data.sensitive_count),
                                        64'(want.sensitive_count));
                    if (out_data.resistant_count !== want.resistant_count)
                        report_mismatch("resistant_count", 64'(out_data.resistant_count),
                                        64'(want.resistant_count));
                    if (out_data.elapsed_time !== want.elapsed_time)
                        report_mismatch("elapsed_time", 64'(out_data.elapsed_time),
                                        64'(want.elapsed_time));
                    if (out_data.event_kind !== want.event_kind)
                        report_mismatch("event_kind", 64'(out_data.event_kind),
                                        64'(want.event_kind));
                    if (out_data.run_status !== want.run_status)
                        report_mismatch("run_status", 64'(out_data.run_status),
                                        64'(want.run_status));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Writes one register and mirrors it in the model copy. The block is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MODE:      mdl_mode = val[0];
            CFG_KILL_S:    mdl_kill_s = val[25:0];
            CFG_KILL_R:    mdl_kill_r = val[25:0];
            CFG_TREAT_END: mdl_treat_end = val;
            CFG_BIRTH_S:   mdl_birth_s = val[23:0];
            CFG_BIRTH_R:   mdl_birth_r = val[23:0];
            CFG_CROWD:     mdl_crowd = val;
            default:       mdl_init_s = val[15:0];
        endcase
    endtask

    task automatic set_all(input logic mode, input logic [25:0] ks, input logic [25:0] kr,
                           input logic [31:0] tend, input logic [23:0] bs,
                           input logic [23:0] br, input logic [31:0] crowd,
                           input logic [15:0] init_s);
        write_reg(CFG_MODE, 32'(mode));
        write_reg(CFG_KILL_S, 32'(ks));
        write_reg(CFG_KILL_R, 32'(kr));
        write_reg(CFG_TREAT_END, tend);
        write_reg(CFG_BIRTH_S, 32'(bs));
        write_reg(CFG_BIRTH_R, 32'(br));
        write_reg(CFG_CROWD, crowd);
        write_reg(CFG_INIT_S, 32'(init_s));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic act, input logic [31:0] u, input logic [31:0] e);
        in_t it;
        it.action = act;
        it.uniform_draw = u;
        it.exp_draw = e;
        pending_items.push_back(it);
    endtask

    // A short exponential-style draw most of the time, the full range now and then.
    function automatic logic [31:0] wait_draw();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($urandom_range(32'h0400_0000));
    endfunction

    // Mostly well-formed runs: a start followed by a burst of events. The rest
    // is noise with a random action.
    task automatic queue_runs(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_item(1'($urandom), $urandom, $urandom);
                left--;
            end
            else
            begin
                len = $urandom_range(60, 5);
                push_item(1'b0, $urandom, $urandom);
                for (int k = 0; k < len; k++)
                    push_item(1'b1, $urandom, wait_draw());
                left -= len + 1;
            end
        end
    endtask

    // Lets every queued item through, then lets the block settle.
    task automatic drain();
        wait (pending_items.size() == 0 && predicted_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mdl_mode = 1'b0;
        mdl_kill_s = '0;
        mdl_kill_r = '0;
        mdl_treat_end = '0;
        mdl_birth_s = BIRTH_S_RST;
        mdl_birth_r = BIRTH_R_RST;
        mdl_crowd = CROWD_RST;
        mdl_init_s = INIT_S_RST;
        pop_s = '0;
        pop_r = '0;
        sim_clock = '0;
        after_treatment = 1'b0;
        run_state = RUN_FAILED;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset settings. An event before any start must
        // leave everything alone, as must events once a run has ended.
        push_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(1'b1, 32'h0, 32'h0);
        push_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(1'b1, 32'h8000_0000, 32'h0100_0000);
        push_item(1'b1, 32'hC000_0000, 32'h0100_0000);
        push_item(1'b1, 32'hFFFF_FFFF, 32'h0);
        drain();

        // A resistant strain of one with no birth, one death ends the run
        // before the treatment time: a failed run, then a dead run.
        set_all(1'b1, 26'h3FF_FFFF, 26'h3FF_FFFF, 32'hFFFF_FFFF, 24'h0, 24'h0,
                32'hFFFF_FFFF, 16'h0);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(1'b1, 32'h1234_5678, 32'h1);
        // Treatment time zero: the first event ends treatment, and an empty
        // sensitive strain is raised to one.
        drain();
        set_all(1'b0, 26'h0, 26'h0, 32'h0, 24'h0, 24'hFF_FFFF, 32'h0, 16'h0);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'h0, 32'hFFFF_FFFF);
        push_item(1'b1, 32'h0, 32'hFFFF_FFFF);
        push_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Saturation of the sensitive count at its maximum.
        drain();
        set_all(1'b0, 26'h0, 26'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'h0, 32'h0, 16'hFFFF);
        push_item(1'b0, 32'h0, 32'h0);
        push_item(1'b1, 32'h0, 32'h0);
        push_item(1'b1, 32'h0, 32'hFFFF_FFFF);
        push_item(1'b1, 32'hFFFF_FFFF, 32'h0);
        drain();

        // Random phases over several settings and idling patterns.
        send_idle_pct = 70;
        set_all(1'b1, 26'h002_0000, 26'h0, 32'h0002_0000, BIRTH_S_RST, BIRTH_R_RST,
                32'h1000_0000, 16'd20);
        queue_runs(300);
        drain();

        // In this phase the sender never idles and the receiver stalls most of the time.
        send_idle_pct = 0;
        recv_stall_pct = 70;
        set_all(1'b0, 26'h3FF_FFFF, 26'h3FF_FFFF, 32'h0, 24'hFF_FFFF, 24'h01_0000,
                32'hFFFF_FFFF, 16'd0);
        queue_runs(300);
        drain();

        send_idle_pct = 33;
        recv_stall_pct = 33;
        set_all(1'b0, 26'h008_0000, 26'h001_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'h0,
                32'h0, 16'hFFFF);
        queue_runs(200);
        drain();

        set_all(1'b1, 26'h0, 26'h0, 32'h0000_8000, 24'h0, 24'h0, 32'hFFFF_FFFF, 16'd3);
        queue_runs(400);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_all(1'b0, 26'h000_8000, 26'h000_4000, 32'h0004_0000, BIRTH_S_RST, BIRTH_R_RST,
                CROWD_RST, 16'd10);
        queue_runs(200);
        drain();
        send_idle_pct = 33;
        recv_stall_pct = 33;
        queue_runs(200);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
hdl/tsbdssa_pkg.sv
hdl/two_strain_birth_death_ssa_step.sv
hdl/tsbdssa_checker.sv
tb/two_strain_birth_death_ssa_step_tb.sv
